>>> rtl/lpa_pkg.sv
// Shared constants and codes for the linked pool allocator.
package lpa_pkg;

  // Default pool size.
  localparam int unsigned POOL_ENTRIES_DEF = 32;

  // Fixed field widths on the stream ports.
  localparam int unsigned OPCODE_W = 1;
  localparam int unsigned ENTRY_W  = 5;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 8;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE       = 2'd0,
    ST_EMPTY      = 2'd1,
    ST_NOT_ACTIVE = 2'd2
  } status_e;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_ALLOC  = 6'b000010,
    S_HEAD   = 6'b000100,
    S_WALK   = 6'b001000,
    S_UNLINK = 6'b010000,
    S_PUSH   = 6'b100000
  } state_e;

endpackage

>>> rtl/lpa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module lpa_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/linked_pool_allocator_top.sv
// Top level of the linked pool allocator: free list, active list, stream ports.
//
// The pool holds POOL_ENTRIES entries threaded on two singly linked lists that
// share one next-pointer RAM: a free list and an active list. A link equal to
// POOL_ENTRIES is the null link. An allocate beat pops the free-list head,
// pushes it on the front of the active list and returns its number (status
// done), or returns status pool-empty when the free list is empty. A free beat
// walks the active list from its head, one link per cycle through the RAM's
// single registered read port, unlinks the named entry and pushes it on the
// free list; an entry number that is out of range or not on the active list
// gives status not-active and changes nothing. Allocate reads the link behind
// the free head, then answers from S_ALLOC; freeing the active head reads its
// link, then answers from S_HEAD; freeing deeper steps through S_WALK link by
// link, then S_UNLINK and S_PUSH, and a failed walk answers from S_WALK.
// A beat refused at once (allocate on an empty pool, free with an empty active
// list or an out-of-range number) is answered in the cycle after it is taken.
// One item is in work at a time; the result sits in an output register, so the
// next input beat is taken as soon as that register is free or being emptied.
// Valid bits in flip-flops stand in for the RAM's reset image (entry i links
// to i + 1), so the block is ready right after reset with no clearing pass.
module linked_pool_allocator_top
  import lpa_pkg::*;
#(
  parameter int unsigned POOL_ENTRIES = POOL_ENTRIES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Request stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [0] opcode, [5:1] entry_number
  // Result stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [1:0] status, [6:2] granted_entry
);

  localparam int unsigned IW = $clog2(POOL_ENTRIES);       // entry index width
  localparam int unsigned LW = $clog2(POOL_ENTRIES + 1);   // link width incl. null
  localparam int unsigned CW = (LW > ENTRY_W) ? LW : ENTRY_W;
  localparam logic [LW-1:0] LINK_NULL = LW'(POOL_ENTRIES);

  // Input beat fields.
  opcode_e             in_opcode;
  logic [ENTRY_W-1:0]  in_entry;
  logic [CW-1:0]       in_entry_ext;
  logic                in_entry_ok;

  assign in_opcode    = opcode_e'(s_axis_tdata[0]);
  assign in_entry     = s_axis_tdata[ENTRY_W:1];
  assign in_entry_ext = CW'(in_entry);
  assign in_entry_ok  = in_entry_ext < CW'(POOL_ENTRIES);

  // Control and list registers.
  state_e          state_q, state_d;
  logic [LW-1:0]   free_head_q, free_head_d;
  logic [LW-1:0]   active_head_q, active_head_d;
  logic [LW-1:0]   prev_q, prev_d;
  logic [LW-1:0]   tgt_q, tgt_d;
  logic [LW-1:0]   steps_q, steps_d;

  // Output register.
  logic                m_valid_q, m_valid_d;
  status_e             m_status_q, m_status_d;
  logic [ENTRY_W-1:0]  m_granted_q, m_granted_d;

  // RAM access.
  logic            rd_en;
  logic [IW-1:0]   rd_addr;
  logic [IW-1:0]   rd_addr_q;
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  logic [LW-1:0]   wr_data;
  logic [LW-1:0]   ram_rd_data;
  logic [LW-1:0]   link_rd;
  logic [POOL_ENTRIES-1:0] valid_q;

  logic            out_free;
  logic            in_acc;
  logic            emit;
  status_e         emit_status;
  logic [ENTRY_W-1:0] emit_granted;

  lpa_ram #(
    .WIDTH (LW),
    .DEPTH (POOL_ENTRIES)
  ) u_link_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (ram_rd_data)
  );

  // An entry never written still holds its reset link: next index, or null.
  assign link_rd = valid_q[rd_addr_q] ? ram_rd_data : (LW'(rd_addr_q) + LW'(1));

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d       = state_q;
    free_head_d   = free_head_q;
    active_head_d = active_head_q;
    prev_d        = prev_q;
    tgt_d         = tgt_q;
    steps_d       = steps_q;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    emit          = 1'b0;
    emit_status   = ST_DONE;
    emit_granted  = '0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_opcode == OP_ALLOC) begin
            if (free_head_q >= LINK_NULL) begin
              emit        = 1'b1;
              emit_status = ST_EMPTY;
            end else begin
              // Fetch the link behind the free head.
              rd_en   = 1'b1;
              rd_addr = free_head_q[IW-1:0];
              state_d = S_ALLOC;
            end
          end else if (!in_entry_ok || active_head_q >= LINK_NULL) begin
            emit        = 1'b1;
            emit_status = ST_NOT_ACTIVE;
          end else begin
            tgt_d = LW'(in_entry_ext);
            if (active_head_q == LW'(in_entry_ext)) begin
              rd_en   = 1'b1;
              rd_addr = in_entry_ext[IW-1:0];
              state_d = S_HEAD;
            end else begin
              // Start the walk at the active head.
              rd_en   = 1'b1;
              rd_addr = active_head_q[IW-1:0];
              prev_d  = active_head_q;
              steps_d = '0;
              state_d = S_WALK;
            end
          end
        end
      end

      S_ALLOC: begin
        if (out_free) begin
          free_head_d   = link_rd;
          wr_en         = 1'b1;
          wr_addr       = free_head_q[IW-1:0];
          wr_data       = active_head_q;
          active_head_d = free_head_q;
          emit          = 1'b1;
          emit_status   = ST_DONE;
          emit_granted  = ENTRY_W'(free_head_q);
          state_d       = S_IDLE;
        end
      end

      S_HEAD: begin
        if (out_free) begin
          active_head_d = link_rd;
          wr_en         = 1'b1;
          wr_addr       = tgt_q[IW-1:0];
          wr_data       = free_head_q;
          free_head_d   = tgt_q;
          emit          = 1'b1;
          emit_status   = ST_DONE;
          state_d       = S_IDLE;
        end
      end

      S_WALK: begin
        // link_rd is the entry that follows prev_q.
        if (steps_q == LINK_NULL || link_rd >= LINK_NULL) begin
          if (out_free) begin
            emit        = 1'b1;
            emit_status = ST_NOT_ACTIVE;
            state_d     = S_IDLE;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = link_rd[IW-1:0];
          if (link_rd == tgt_q) begin
            state_d = S_UNLINK;
          end else begin
            prev_d  = link_rd;
            steps_d = steps_q + LW'(1);
          end
        end
      end

      S_UNLINK: begin
        // Bridge prev over the target.
        wr_en   = 1'b1;
        wr_addr = prev_q[IW-1:0];
        wr_data = link_rd;
        state_d = S_PUSH;
      end

      S_PUSH: begin
        if (out_free) begin
          wr_en       = 1'b1;
          wr_addr     = tgt_q[IW-1:0];
          wr_data     = free_head_q;
          free_head_d = tgt_q;
          emit        = 1'b1;
          emit_status = ST_DONE;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    m_valid_d   = m_valid_q;
    m_status_d  = m_status_q;
    m_granted_d = m_granted_q;
    if (emit) begin
      m_valid_d   = 1'b1;
      m_status_d  = emit_status;
      m_granted_d = emit_granted;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      free_head_q   <= '0;
      active_head_q <= LINK_NULL;
      m_valid_q     <= 1'b0;
      valid_q       <= '0;
    end else begin
      state_q       <= state_d;
      free_head_q   <= free_head_d;
      active_head_q <= active_head_d;
      m_valid_q     <= m_valid_d;
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q      <= prev_d;
    tgt_q       <= tgt_d;
    steps_q     <= steps_d;
    m_status_q  <= m_status_d;
    m_granted_q <= m_granted_d;
    if (rd_en) begin
      rd_addr_q <= rd_addr;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({m_granted_q, m_status_q});

endmodule
